[hdl/slii_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package slii_pkg;

	// Default sizing of the store.
	localparam int CAPACITY    = 16;
	localparam int VALUE_WIDTH = 32;

	// Fixed port widths.
	localparam int PORT_VALUE_W = 32;
	localparam int POSITION_W   = 4;
	localparam int ENTRY_CNT_W  = 5;

	typedef enum logic [1:0] {
		OP_INSERT    = 2'd0,
		OP_READ_ASC  = 2'd1,
		OP_READ_DESC = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_RANGE = 2'd2
	} status_t;

	// Control handed to every cell of the chain in the cycle of a transaction.
	typedef struct packed {
		logic ins_en;
	} cell_ctrl_t;

endpackage

`default_nettype wire

[hdl/slii_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module slii_cell #(
	parameter int VALUE_WIDTH = slii_pkg::VALUE_WIDTH,
	parameter int CNT_W       = 5,
	parameter int INDEX       = 0
) (
	input  wire                          clk,
	input  wire slii_pkg::cell_ctrl_t    ctrl,
	input  wire logic [CNT_W-1:0]        count,
	input  wire logic [VALUE_WIDTH-1:0]  new_value,
	input  wire logic [VALUE_WIDTH-1:0]  prev_value,
	input  wire logic                    prev_ge,
	output logic      [VALUE_WIDTH-1:0]  value,
	output logic                         ge
);

	logic [VALUE_WIDTH-1:0] value_q;
	logic                   occupied;
	logic                   at_end;

	// The cell holds a live entry when its place lies below the count, and it is
	// the first free place when its place equals the count.
	assign occupied = count > CNT_W'(INDEX);
	assign at_end   = count == CNT_W'(INDEX);

	// A live entry that is not smaller than the new value must move up one place.
	assign ge    = occupied && !($signed(value_q) < $signed(new_value));
	assign value = value_q;

	// Take the neighbour's entry when it moves up, otherwise take the new value
	// when this is the insertion point, otherwise hold.
	always_ff @(posedge clk) begin
		if (ctrl.ins_en) begin
			if (prev_ge) begin
				value_q <= prev_value;
			end else if (ge || at_end) begin
				value_q <= new_value;
			end
		end
	end

endmodule

`default_nettype wire

[hdl/sorted_list_insert_and_index_read.sv]
// Channel   Ports                                   Handshake
// -------   -------------------------------------   ---------------------------------
// command   opcode, new_value, position             taken when start && !busy
// result    read_value, status, entry_count         shown for one cycle while done
//
// Every command transaction is finished in the cycle in which it is taken: the
// row of cells compares all entries against the new value and shifts at that
// same clock edge, and the result is registered and shown in the next cycle.
// A command may therefore be issued in every cycle; busy stays low.
// Reset clears the entry count and the result strobe; the cells themselves
// are not cleared, as entries are never read before they are written.
// The receiver cannot stall: each result is present for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module sorted_list_insert_and_index_read #(
	parameter int CAPACITY    = slii_pkg::CAPACITY,
	parameter int VALUE_WIDTH = slii_pkg::VALUE_WIDTH
) (
	input  wire                                       clk,
	input  wire                                       arst_n,
	input  wire                                       start,
	output logic                                      busy,
	input  wire logic [1:0]                           opcode,
	input  wire logic signed [slii_pkg::PORT_VALUE_W-1:0] new_value,
	input  wire logic [slii_pkg::POSITION_W-1:0]      position,
	output logic                                      done,
	output logic signed [slii_pkg::PORT_VALUE_W-1:0]  read_value,
	output logic [1:0]                                status,
	output logic [slii_pkg::ENTRY_CNT_W-1:0]          entry_count
);

	// Widths that follow from the size of the store. The comparison width is
	// wide enough for the count, the position port and the reported count.
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CMP_A  = (CNT_W > slii_pkg::POSITION_W) ? CNT_W : slii_pkg::POSITION_W;
	localparam int CMP_W  = (CMP_A > slii_pkg::ENTRY_CNT_W) ? CMP_A : slii_pkg::ENTRY_CNT_W;
	localparam int PV_W   = slii_pkg::PORT_VALUE_W;

	logic                   accept;
	slii_pkg::cell_ctrl_t   cell_ctrl;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       count_next;
	logic                   full;
	logic [VALUE_WIDTH-1:0] ins_value;

	logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
	logic                   cell_ge    [CAPACITY];

	logic [CMP_W-1:0]       count_ext;
	logic [CMP_W-1:0]       pos_ext;
	logic [CMP_W-1:0]       next_ext;
	logic [CMP_W-1:0]       desc_idx;
	logic [IDX_W-1:0]       rd_idx;
	logic [VALUE_WIDTH-1:0] rd_entry;
	logic [PV_W-1:0]        rd_port;

	logic                   done_q;
	logic [PV_W-1:0]        read_value_q;
	slii_pkg::status_t      status_q;
	logic [slii_pkg::ENTRY_CNT_W-1:0] entry_count_q;

	logic [PV_W-1:0]        res_value;
	slii_pkg::status_t      res_status;

	// Every command completes in its own cycle, so the block never holds off.
	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = count_q == CNT_W'(CAPACITY);

	// The incoming value is narrowed or sign-extended to the stored width.
	always_comb begin
		for (int b = 0; b < VALUE_WIDTH; b++) begin
			ins_value[b] = new_value[(b < PV_W) ? b : PV_W - 1];
		end
	end

	assign cell_ctrl.ins_en = accept && (opcode == slii_pkg::OP_INSERT) && !full;
	assign count_next       = cell_ctrl.ins_en ? count_q + CNT_W'(1) : count_q;

	// The chain of cells. Each cell sees the entry and the shift flag of its
	// lower neighbour; the lowest cell has no neighbour and never takes one.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VALUE_WIDTH-1:0] prev_value;
		logic                   prev_ge;

		if (i == 0) begin : g_first
			assign prev_value = '0;
			assign prev_ge    = 1'b0;
		end else begin : g_rest
			assign prev_value = cell_value[i-1];
			assign prev_ge    = cell_ge[i-1];
		end

		slii_cell #(
			.VALUE_WIDTH (VALUE_WIDTH),
			.CNT_W       (CNT_W),
			.INDEX       (i)
		) u_cell (
			.clk        (clk),
			.ctrl       (cell_ctrl),
			.count      (count_q),
			.new_value  (ins_value),
			.prev_value (prev_value),
			.prev_ge    (prev_ge),
			.value      (cell_value[i]),
			.ge         (cell_ge[i])
		);
	end

	// Read addressing. A descending read counts back from the last live entry;
	// the subtraction is only used once the position is known to be in range.
	assign count_ext = CMP_W'(count_q);
	assign pos_ext   = CMP_W'(position);
	assign next_ext  = CMP_W'(count_next);
	assign desc_idx  = count_ext - CMP_W'(1) - pos_ext;
	assign rd_idx    = (opcode == slii_pkg::OP_READ_DESC) ? desc_idx[IDX_W-1:0]
	                                                     : pos_ext[IDX_W-1:0];
	assign rd_entry  = cell_value[rd_idx];

	// The stored entry is shown on the port sign-extended or narrowed.
	always_comb begin
		for (int b = 0; b < PV_W; b++) begin
			rd_port[b] = rd_entry[(b < VALUE_WIDTH) ? b : VALUE_WIDTH - 1];
		end
	end

	// Result of the command taken in this cycle.
	always_comb begin
		res_value  = '0;
		res_status = slii_pkg::STATUS_OK;
		unique case (opcode) inside
			slii_pkg::OP_INSERT: begin
				if (full) begin
					res_status = slii_pkg::STATUS_FULL;
				end
			end
			slii_pkg::OP_READ_ASC, slii_pkg::OP_READ_DESC: begin
				if (pos_ext >= count_ext) begin
					res_status = slii_pkg::STATUS_RANGE;
				end else begin
					res_value = rd_port;
				end
			end
			default: begin
				res_value  = '0;
				res_status = slii_pkg::STATUS_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_next;
			done_q  <= accept;
		end
	end

	// Result payload, loaded with each transaction.
	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q  <= res_value;
			status_q      <= res_status;
			entry_count_q <= next_ext[slii_pkg::ENTRY_CNT_W-1:0];
		end
	end

	assign done        = done_q;
	assign read_value  = read_value_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;

	// The count never grows beyond the size of the store.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count exceeds capacity");

	// One result follows every accepted command, and none appears otherwise.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("accepted command gave no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !done)
		else $error("result without a command");

	// An insert into a full store leaves the count alone and reports it.
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == slii_pkg::OP_INSERT && full)
		|=> ($stable(count_q) && status == slii_pkg::STATUS_FULL))
		else $error("insert into full store was not dropped");

	// A successful insert raises the count by exactly one.
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		cell_ctrl.ins_en |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not advance the count");

endmodule

`default_nettype wire

[tb/tb_sorted_list_insert_and_index_read.sv]
`timescale 1ns / 1ps

module tb_sorted_list_insert_and_index_read;

	localparam int PV_W  = slii_pkg::PORT_VALUE_W;
	localparam int POS_W = slii_pkg::POSITION_W;
	localparam int CNT_W = slii_pkg::ENTRY_CNT_W;

	// Opcode 3 has no meaning to the block. It must leave the store alone and answer OK.
	localparam logic [1:0] OPCODE_UNUSED = 2'd3;

	// The values that one result transaction should carry.
	typedef struct {
		logic signed [PV_W-1:0] value;
		slii_pkg::status_t      code;
		logic [CNT_W-1:0]       count;
	} store_answer_t;

	// Shadow copy of the sorted store. It keeps its own ascending list and the
	// answers still owed by the block, oldest first.
	class sorted_store_scoreboard;
		logic signed [PV_W-1:0] entries[$];
		store_answer_t          owed[$];
		int unsigned            mismatches;

		function new();
			mismatches = 0;
		endfunction

		function int unsigned outstanding();
			return owed.size();
		endfunction

		// Called for every command transaction that the block has taken.
		function void note_command(logic [1:0] op, logic signed [PV_W-1:0] val,
				logic [POS_W-1:0] pos);
			store_answer_t answer;
			int unsigned slot;
			answer.value = '0;
			answer.code  = slii_pkg::STATUS_OK;
			case (op) inside
				slii_pkg::OP_INSERT: begin
					if (entries.size() >= slii_pkg::CAPACITY) begin
						answer.code = slii_pkg::STATUS_FULL;
					end else begin
						// The new value goes ahead of the first entry that is not smaller.
						slot = 0;
						while (slot < entries.size() && entries[slot] < val)
							slot++;
						entries.insert(slot, val);
					end
				end
				slii_pkg::OP_READ_ASC, slii_pkg::OP_READ_DESC: begin
					if (pos >= entries.size()) begin
						answer.code = slii_pkg::STATUS_RANGE;
					end else if (op == slii_pkg::OP_READ_ASC) begin
						answer.value = entries[pos];
					end else begin
						answer.value = entries[entries.size() - 1 - pos];
					end
				end
				default: ;
			endcase
			answer.count = CNT_W'(entries.size());
			owed.push_back(answer);
		endfunction

		// Called for every result transaction shown by the block.
		function void check_result(logic signed [PV_W-1:0] value, logic [1:0] code,
				logic [CNT_W-1:0] count);
			store_answer_t answer;
			if (owed.size() == 0) begin
				$display("%0t: unexpected result, value %0d status %0d count %0d",
					$time, value, code, count);
				mismatches++;
				return;
			end
			answer = owed.pop_front();
			if (value !== answer.value) begin
				$display("%0t: read_value expected %0d, actual %0d", $time, answer.value, value);
				mismatches++;
			end
			if (code !== answer.code) begin
				$display("%0t: status expected %0d, actual %0d", $time, answer.code, code);
				mismatches++;
			end
			if (count !== answer.count) begin
				$display("%0t: entry_count expected %0d, actual %0d", $time, answer.count, count);
				mismatches++;
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic [1:0]             opcode = '0;
	logic signed [PV_W-1:0] new_value = '0;
	logic [POS_W-1:0]       position = '0;
	logic                   busy;
	logic                   done;
	logic signed [PV_W-1:0] read_value;
	logic [1:0]             status;
	logic [CNT_W-1:0]       entry_count;

	sorted_store_scoreboard sb = new();

	// The chance, in percent, that the sender goes on idling instead of issuing the next transaction.
	int unsigned sender_idle_pct = 0;

	sorted_list_insert_and_index_read u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.opcode      (opcode),
		.new_value   (new_value),
		.position    (position),
		.done        (done),
		.read_value  (read_value),
		.status      (status),
		.entry_count (entry_count)
	);

	always #5 clk = ~clk;

	// A result cannot be held off. The strobe is sampled at each rising edge,
	// and the check uses the values that the block held just before that edge.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(read_value, status, entry_count);
	end

	// Issues one command transaction. First come random idle cycles. While idling,
	// start is low and the payload carries junk, which the block must ignore. The
	// task returns at the edge that takes the transaction. If the next call issues
	// at once, start simply stays high.
	task automatic issue_command(input logic [1:0] op, input logic signed [PV_W-1:0] val,
			input logic [POS_W-1:0] pos);
		while ($urandom_range(99) < sender_idle_pct) begin
			start     <= 1'b0;
			opcode    <= 2'($urandom);
			new_value <= $urandom;
			position  <= POS_W'($urandom);
			@(posedge clk);
		end
		start     <= 1'b1;
		opcode    <= op;
		new_value <= val;
		position  <= pos;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_command(op, val, pos);
	endtask

	// Random commands once the store is full. Most are reads in either direction at
	// any position. The rest are inserts that must be dropped, plus the odd unused opcode.
	task automatic run_random_phase(input int unsigned count);
		int unsigned pick;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 3)
				issue_command(OPCODE_UNUSED, $urandom, POS_W'($urandom));
			else if (pick < 25)
				issue_command(slii_pkg::OP_INSERT, $urandom, POS_W'($urandom));
			else if (pick < 62)
				issue_command(slii_pkg::OP_READ_ASC, $urandom, POS_W'($urandom));
			else
				issue_command(slii_pkg::OP_READ_DESC, $urandom, POS_W'($urandom));
		end
	endtask

	// Watchdog that ends a run which does not finish as failed.
	initial begin
		#2ms;
		$display("Verification failed");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with the sender idling now and then.
		sender_idle_pct = 27;

		// Reads of an empty store are out of range whichever way they count.
		issue_command(slii_pkg::OP_READ_ASC, $urandom, 4'd0);
		issue_command(slii_pkg::OP_READ_DESC, $urandom, 4'd15);
		issue_command(OPCODE_UNUSED, 32'sh7FFF_FFFF, 4'd15);

		// The extremes of the value range, zero, its neighbours and duplicates.
		// Each duplicate is placed next to its twin.
		issue_command(slii_pkg::OP_INSERT, 32'sh7FFF_FFFF, 4'd0);
		issue_command(slii_pkg::OP_INSERT, 32'sh8000_0000, 4'd15);
		issue_command(slii_pkg::OP_INSERT, 32'sh0000_0000, 4'd0);
		issue_command(slii_pkg::OP_INSERT, -32'sd1, 4'd0);
		issue_command(slii_pkg::OP_INSERT, 32'sd1, 4'd0);
		issue_command(slii_pkg::OP_INSERT, 32'sh7FFF_FFFF, 4'd0);
		issue_command(slii_pkg::OP_INSERT, 32'sh8000_0000, 4'd0);

		// Both ends of a partly filled store. One read lands just past the count,
		// and one descending read reaches the smallest entry.
		issue_command(slii_pkg::OP_READ_ASC, $urandom, 4'd0);
		issue_command(slii_pkg::OP_READ_DESC, $urandom, 4'd0);
		issue_command(slii_pkg::OP_READ_ASC, $urandom, 4'd7);
		issue_command(slii_pkg::OP_READ_DESC, $urandom, 4'd6);
		issue_command(slii_pkg::OP_READ_ASC, $urandom, 4'd3);

		// Fill the rest of the store with random values. The last insert must then
		// be dropped as full.
		repeat (slii_pkg::CAPACITY - 7)
			issue_command(slii_pkg::OP_INSERT, $urandom, POS_W'($urandom));
		issue_command(slii_pkg::OP_INSERT, $urandom, 4'd0);
		issue_command(slii_pkg::OP_READ_ASC, $urandom, 4'd15);
		issue_command(slii_pkg::OP_READ_DESC, $urandom, 4'd15);

		// Random part, run at three levels of sender idling. The last level keeps the
		// block taking a transaction on every cycle.
		run_random_phase(176);
		sender_idle_pct = 80;
		run_random_phase(176);
		sender_idle_pct = 0;
		run_random_phase(176);
		start <= 1'b0;

		// Drain the last results, then wait on for any stray strobe.
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (sb.mismatches == 0 && sb.outstanding() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
